// ===== design/ttb_pkg.sv =====
// Package for the triangle tangent basis unit: widths and the sequencer state
// types of the top level and the normalizer. No dependencies.
`timescale 1ns / 1ps
package ttb_pkg;

    // Fixed normalization target bit length.
    localparam int NORM_BITS = 30;
    // Spare product width; the top level sizes its exact edge products itself.
    localparam int PROD_W = 72;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET,
        ST_TB,
        ST_NORM_LOAD,
        ST_NORM_SHIFT,
        ST_NORM_SUM,
        ST_NORM_SQRT,
        ST_NORM_DIV,
        ST_NORM_DONE,
        ST_CROSS,
        ST_OUT
    } state_t;

    // Normalizer sequencer states.
    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SUM,
        N_SQRT,
        N_DIV,
        N_DONE
    } norm_state_t;

endpackage

// ===== design/ttb_norm.sv =====
// Vector normalizer for the tangent basis unit: scales a three-component
// exact vector to unit length in Q1.F using a bit-serial square root and
// restoring divider. Depends on ttb_pkg.
`timescale 1ns / 1ps
module ttb_norm #(
    parameter int IN_W = 72,
    parameter int FRAC = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [IN_W-1:0] vx,
    input  logic signed [IN_W-1:0] vy,
    input  logic signed [IN_W-1:0] vz,
    input  logic                   negate,
    output logic                   done,
    output logic signed [FRAC+1:0] ux,
    output logic signed [FRAC+1:0] uy,
    output logic signed [FRAC+1:0] uz
);
    localparam int NB = ttb_pkg::NORM_BITS;
    localparam int LW = $clog2(IN_W + 1);
    localparam int SW = 2 * NB + 2;
    localparam int QW = NB + FRAC + 1;
    localparam int SQ_STEPS = (SW + 1) / 2;

    ttb_pkg::norm_state_t   state_reg, state_next;
    logic [IN_W-1:0]        mag_reg [3];
    logic [2:0]             neg_reg;
    logic [NB-1:0]          c_reg [3];
    logic [SW-1:0]          sum_reg;
    logic [SW-1:0]          rem_reg;
    logic [SW-1:0]          root_reg;
    logic [$clog2(QW+1)-1:0] cnt_reg;
    logic [1:0]             idx_reg;
    logic [QW-1:0]          num_reg;
    logic [NB+1:0]          drem_reg;
    logic [QW-1:0]          quo_reg;
    logic signed [FRAC+1:0] res_reg [3];
    logic                   zero_reg;

    logic [IN_W-1:0] m0, m1, m2, mor;
    logic [LW-1:0]   blen;
    logic [NB:0]     root_n;

    // Magnitude of each input component.
    always_comb
    begin
        m0 = vx[IN_W-1] ? IN_W'(-vx) : IN_W'(vx);
        m1 = vy[IN_W-1] ? IN_W'(-vy) : IN_W'(vy);
        m2 = vz[IN_W-1] ? IN_W'(-vz) : IN_W'(vz);
    end

    // Bit length of the largest stored magnitude.
    always_comb
    begin
        mor = mag_reg[0] | mag_reg[1] | mag_reg[2];
        blen = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (mor[i])
            begin
                blen = LW'(i + 1);
            end
        end
    end

    // The root of three squares of 30-bit values needs 31 bits.
    assign root_n = root_reg[NB:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttb_pkg::N_IDLE:
                if (start) state_next = ttb_pkg::N_SHIFT;
            ttb_pkg::N_SHIFT:
                state_next = ttb_pkg::N_SUM;
            ttb_pkg::N_SUM:
                if (idx_reg == 2'd2)
                    state_next = zero_reg ? ttb_pkg::N_DONE : ttb_pkg::N_SQRT;
            ttb_pkg::N_SQRT:
                if (cnt_reg == '0) state_next = ttb_pkg::N_DIV;
            ttb_pkg::N_DIV:
                if (cnt_reg == '0 && idx_reg == 2'd2) state_next = ttb_pkg::N_DONE;
            ttb_pkg::N_DONE:
                state_next = ttb_pkg::N_IDLE;
            default:
                state_next = ttb_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath: one shared square product, one root bit, one quotient bit a cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ttb_pkg::N_IDLE:
            begin
                mag_reg[0] <= m0;
                mag_reg[1] <= m1;
                mag_reg[2] <= m2;
                neg_reg <= {vz[IN_W-1] ^ negate, vy[IN_W-1] ^ negate,
                            vx[IN_W-1] ^ negate};
            end
            ttb_pkg::N_SHIFT:
            begin
                zero_reg <= (blen == '0);
                for (int i = 0; i < 3; i++)
                begin
                    if (int'(blen) > NB)
                        c_reg[i] <= NB'(mag_reg[i] >> (int'(blen) - NB));
                    else
                        c_reg[i] <= NB'(mag_reg[i] << (NB - int'(blen)));
                    res_reg[i] <= '0;
                end
                sum_reg <= '0;
                idx_reg <= 2'd0;
            end
            ttb_pkg::N_SUM:
            begin
                sum_reg <= sum_reg + SW'(c_reg[idx_reg] * c_reg[idx_reg]);
                idx_reg <= idx_reg + 2'd1;
                rem_reg <= '0;
                root_reg <= '0;
                cnt_reg <= ($bits(cnt_reg))'(SQ_STEPS - 1);
            end
            ttb_pkg::N_SQRT:
            begin
                // Classic digit-by-digit root: two radicand bits per step.
                logic [SW-1:0] r2, trial;
                r2 = {rem_reg[SW-3:0], sum_reg[SW-1:SW-2]};
                trial = {root_reg[SW-3:0], 2'b01};
                sum_reg <= {sum_reg[SW-3:0], 2'b00};
                if (r2 >= trial)
                begin
                    rem_reg <= r2 - trial;
                    root_reg <= {root_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2;
                    root_reg <= {root_reg[SW-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    // Before the last root bit the partial root is already half
                    // the final root, which is the rounding term.
                    idx_reg <= 2'd0;
                    cnt_reg <= ($bits(cnt_reg))'(QW - 1);
                    num_reg <= QW'({c_reg[0], {FRAC{1'b0}}})
                               + QW'(root_reg[NB-1:0]);
                    drem_reg <= '0;
                    quo_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            ttb_pkg::N_DIV:
            begin
                logic [NB+1:0] d2;
                logic [QW-1:0] q;
                logic [QW:0]   one;
                d2 = {drem_reg[NB:0], num_reg[QW-1]};
                num_reg <= {num_reg[QW-2:0], 1'b0};
                q = {quo_reg[QW-2:0], 1'b0};
                if (d2 >= (NB+2)'(root_n))
                begin
                    drem_reg <= d2 - (NB+2)'(root_n);
                    q[0] = 1'b1;
                end
                else
                begin
                    drem_reg <= d2;
                end
                quo_reg <= q;
                if (cnt_reg == '0)
                begin
                    one = (QW+1)'(1) << FRAC;
                    if ((QW+1)'(q) > one)
                        q = QW'(one);
                    res_reg[idx_reg] <= neg_reg[idx_reg] ? -(FRAC+2)'(q)
                                                         : (FRAC+2)'(q);
                    cnt_reg <= ($bits(cnt_reg))'(QW - 1);
                    drem_reg <= '0;
                    quo_reg <= '0;
                    idx_reg <= idx_reg + 2'd1;
                    num_reg <= QW'({c_reg[(idx_reg == 2'd0) ? 1 : 2],
                                    {FRAC{1'b0}}}) + QW'(root_reg[NB:1]);
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == ttb_pkg::N_DONE);
    assign ux = res_reg[0];
    assign uy = res_reg[1];
    assign uz = res_reg[2];

endmodule

// ===== design/triangle_tangent_basis_unit.sv =====
// Top level of the triangle tangent basis unit: corner store, sequencer,
// shared multiplier and the normalizer. Depends on ttb_pkg and ttb_norm.
`timescale 1ns / 1ps
// Corners stream in one word each; the first two corners of a face are each
// stored as they arrive, and the third starts the face computation. The
// block is not ready again until the face word has been accepted. The face
// word follows the determinant, the edge products, the tangent and
// bitangent normalizations, the cross products, the normal's normalization
// and the output state. Each normalization steps through a load, a shift,
// the sum of the three squares, the serial root, the restoring divider for
// each of the three components and a hand-back of the result. A degenerate
// face finishes after the determinant and goes straight to the output.
module triangle_tangent_basis_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,          // flip_v_sign
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,      // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic         s_axis_tuser,      // face_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,      // tangent xyz, bitangent xyz, normal xyz
    output logic         m_axis_tuser       // degenerate
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW + 1;
    localparam int UW = UNIT_FRAC_BITS + 2;

    ttb_pkg::state_t state_reg, state_next;

    logic               flip_reg;
    logic [1:0]         count_reg;
    logic signed [CW-1:0] p0_reg [3];
    logic signed [CW-1:0] p1_reg [3];
    logic signed [CW-1:0] t0_reg [2];
    logic signed [CW-1:0] t1_reg [2];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [DW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] tw_reg [3];
    logic signed [PW-1:0] bw_reg [3];
    logic signed [PW-1:0] nw_reg [3];
    logic                 dneg_reg;
    logic [3:0]           step_reg;
    logic [1:0]           pass_reg;
    logic signed [UW-1:0] tq_reg [3];
    logic signed [UW-1:0] bq_reg [3];
    logic signed [UW-1:0] nq_reg [3];
    logic                 degen_reg;
    logic                 out_valid_reg;

    logic signed [CW-1:0] in_c [5];
    logic [1:0]           slot;
    logic                 in_fire;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic                 norm_start, norm_done, norm_neg;
    logic signed [PW-1:0] nvx, nvy, nvz;
    logic signed [UW-1:0] ux, uy, uz;

    // Unpack the corner word.
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            in_c[i] = $signed(s_axis_tdata[32*i +: CW]);
        end
    end

    assign s_axis_tready = (state_reg == ttb_pkg::ST_IDLE) && !out_valid_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign slot = s_axis_tuser ? 2'd0 : ((count_reg == 2'd3) ? 2'd0 : count_reg);
    assign cfg_ready = 1'b1;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ttb_pkg::ST_DET:
            begin
                mul_a = step_reg[0] ? du2_reg : du1_reg;
                mul_b = step_reg[0] ? dv1_reg : dv2_reg;
            end
            ttb_pkg::ST_TB:
            begin
                case (step_reg[1:0])
                    2'd0:    begin mul_a = dv2_reg; mul_b = e1_reg[step_reg[3:2]]; end
                    2'd1:    begin mul_a = dv1_reg; mul_b = e2_reg[step_reg[3:2]]; end
                    2'd2:    begin mul_a = du1_reg; mul_b = e2_reg[step_reg[3:2]]; end
                    default: begin mul_a = du2_reg; mul_b = e1_reg[step_reg[3:2]]; end
                endcase
            end
            ttb_pkg::ST_CROSS:
            begin
                case (step_reg[2:0])
                    3'd0:    begin mul_a = DW'(tq_reg[1]); mul_b = DW'(bq_reg[2]); end
                    3'd1:    begin mul_a = DW'(tq_reg[2]); mul_b = DW'(bq_reg[1]); end
                    3'd2:    begin mul_a = DW'(tq_reg[2]); mul_b = DW'(bq_reg[0]); end
                    3'd3:    begin mul_a = DW'(tq_reg[0]); mul_b = DW'(bq_reg[2]); end
                    3'd4:    begin mul_a = DW'(tq_reg[0]); mul_b = DW'(bq_reg[1]); end
                    default: begin mul_a = DW'(tq_reg[1]); mul_b = DW'(bq_reg[0]); end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign prod = PW'(mul_a * mul_b);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttb_pkg::ST_IDLE:
                if (in_fire && slot == 2'd2) state_next = ttb_pkg::ST_DET;
            ttb_pkg::ST_DET:
                if (step_reg[0])
                    state_next = ((acc_reg - prod) == '0) ? ttb_pkg::ST_OUT
                                                          : ttb_pkg::ST_TB;
            ttb_pkg::ST_TB:
                if (step_reg == 4'd11) state_next = ttb_pkg::ST_NORM_LOAD;
            ttb_pkg::ST_NORM_LOAD:
                state_next = ttb_pkg::ST_NORM_SHIFT;
            ttb_pkg::ST_NORM_SHIFT:
                if (norm_done)
                    state_next = (pass_reg == 2'd0) ? ttb_pkg::ST_NORM_LOAD
                               : (pass_reg == 2'd1) ? ttb_pkg::ST_CROSS
                               : ttb_pkg::ST_OUT;
            ttb_pkg::ST_CROSS:
                if (step_reg == 4'd5) state_next = ttb_pkg::ST_NORM_LOAD;
            ttb_pkg::ST_OUT:
                state_next = ttb_pkg::ST_IDLE;
            default:
                state_next = ttb_pkg::ST_IDLE;
        endcase
    end

    // Normalizer hookup.
    always_comb
    begin
        norm_start = (state_reg == ttb_pkg::ST_NORM_LOAD);
        case (pass_reg)
            2'd0:    begin nvx = tw_reg[0]; nvy = tw_reg[1]; nvz = tw_reg[2];
                           norm_neg = dneg_reg; end
            2'd1:    begin nvx = bw_reg[0]; nvy = bw_reg[1]; nvz = bw_reg[2];
                           norm_neg = dneg_reg ^ flip_reg; end
            default: begin nvx = nw_reg[0]; nvy = nw_reg[1]; nvz = nw_reg[2];
                           norm_neg = 1'b0; end
        endcase
    end

    ttb_norm #(
        .IN_W (PW),
        .FRAC (UNIT_FRAC_BITS)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .vx     (nvx),
        .vy     (nvy),
        .vz     (nvz),
        .negate (norm_neg),
        .done   (norm_done),
        .ux     (ux),
        .uy     (uy),
        .uz     (uz)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::ST_IDLE;
            flip_reg <= 1'b1;
            count_reg <= 2'd0;
            out_valid_reg <= 1'b0;
            step_reg <= '0;
            pass_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                flip_reg <= cfg_data;
            if (in_fire)
                count_reg <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
            if (state_reg == ttb_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (state_next != state_reg)
                step_reg <= '0;
            else
                step_reg <= step_reg + 4'd1;
            if (state_reg == ttb_pkg::ST_IDLE)
                pass_reg <= 2'd0;
            else if (state_reg == ttb_pkg::ST_NORM_SHIFT && norm_done)
                pass_reg <= pass_reg + 2'd1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ttb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (slot == 2'd0)
                    begin
                        for (int i = 0; i < 3; i++) p0_reg[i] <= in_c[i];
                        for (int i = 0; i < 2; i++) t0_reg[i] <= in_c[3+i];
                    end
                    else if (slot == 2'd1)
                    begin
                        for (int i = 0; i < 3; i++) p1_reg[i] <= in_c[i];
                        for (int i = 0; i < 2; i++) t1_reg[i] <= in_c[3+i];
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            e1_reg[i] <= DW'(p1_reg[i]) - DW'(p0_reg[i]);
                            e2_reg[i] <= DW'(in_c[i]) - DW'(p0_reg[i]);
                        end
                        du1_reg <= DW'(t1_reg[0]) - DW'(t0_reg[0]);
                        dv1_reg <= DW'(t1_reg[1]) - DW'(t0_reg[1]);
                        du2_reg <= DW'(in_c[3]) - DW'(t0_reg[0]);
                        dv2_reg <= DW'(in_c[4]) - DW'(t0_reg[1]);
                    end
                end
            end
            ttb_pkg::ST_DET:
            begin
                if (!step_reg[0])
                    acc_reg <= prod;
                else
                begin
                    dneg_reg <= acc_reg < prod;
                    degen_reg <= (acc_reg == prod);
                    for (int i = 0; i < 3; i++)
                    begin
                        tq_reg[i] <= '0;
                        bq_reg[i] <= '0;
                        nq_reg[i] <= '0;
                    end
                end
            end
            ttb_pkg::ST_TB:
            begin
                case (step_reg[1:0])
                    2'd0, 2'd2: acc_reg <= prod;
                    2'd1:       tw_reg[step_reg[3:2]] <= acc_reg - prod;
                    default:    bw_reg[step_reg[3:2]] <= acc_reg - prod;
                endcase
            end
            ttb_pkg::ST_NORM_SHIFT:
            begin
                if (norm_done)
                begin
                    case (pass_reg)
                        2'd0:    begin tq_reg[0] <= ux; tq_reg[1] <= uy; tq_reg[2] <= uz; end
                        2'd1:    begin bq_reg[0] <= ux; bq_reg[1] <= uy; bq_reg[2] <= uz; end
                        default: begin nq_reg[0] <= ux; nq_reg[1] <= uy; nq_reg[2] <= uz; end
                    endcase
                end
            end
            ttb_pkg::ST_CROSS:
            begin
                if (!step_reg[0])
                    acc_reg <= prod;
                else
                    nw_reg[step_reg[2:1]] <= acc_reg - prod;
            end
            default:
            begin
            end
        endcase
    end

    // Result word.
    always_comb
    begin
        m_axis_tdata = '0;
        for (int i = 0; i < 3; i++)
        begin
            m_axis_tdata[16*i +: 16]     = 16'(tq_reg[i]);
            m_axis_tdata[16*(3+i) +: 16] = 16'(bq_reg[i]);
            m_axis_tdata[16*(6+i) +: 16] = 16'(nq_reg[i]);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = degen_reg;

endmodule
